### rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg: shared types and constants for the RC4 stream cipher
// Command codes, register indexes, widths and the request structs that pass
// between the sequencer and its two memories.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned PERM_DEPTH        = 256;
  localparam int unsigned DEF_MAX_KEY_BYTES = 256;

  localparam int unsigned KEY_LEN_W = 9;
  localparam int unsigned DROP_W    = 13;

  localparam logic [DROP_W-1:0] DROP_LIMIT = 13'd4096;

  // command codes carried in tuser
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_SCHED = 2'd1;
  localparam logic [1:0] CMD_ENC   = 2'd2;

  // configuration register indexes
  localparam logic CFG_KEY_LENGTH = 1'b0;
  localparam logic CFG_DROP_COUNT = 1'b1;

  typedef struct packed {
    logic       clr;    // drop all entries back to identity
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr;
  } perm_req_t;

  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr;
  } key_req_t;

  typedef struct packed {
    logic [7:0] keystream;
    logic [7:0] result;
  } res_t;

endpackage

### rtl/rc4_perm_ram.sv
// ----------------------------------------------------------------------------
// rc4_perm_ram: 256 x 8 permutation store
// One write and one registered read per cycle, write-first on an address
// match. Per-entry valid bits; an invalid entry reads as its own address.
// ----------------------------------------------------------------------------
module rc4_perm_ram (
  input  logic              clk,
  input  logic              rst_n,
  input  rc4_pkg::perm_req_t req,
  output logic [7:0]        rd_data
);

  logic [7:0]                       mem [rc4_pkg::PERM_DEPTH];
  logic [rc4_pkg::PERM_DEPTH-1:0]   vld_r;
  logic [7:0]                       rdata_r;
  logic                             rvld_r;
  logic [7:0]                       raddr_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.we && (req.waddr == req.raddr)) begin
      rdata_r <= req.wdata;
      rvld_r  <= 1'b1;
    end else begin
      rdata_r <= mem[req.raddr];
      rvld_r  <= vld_r[req.raddr];
    end
    raddr_r <= req.raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.clr) begin
      vld_r <= '0;
    end else if (req.we) begin
      vld_r[req.waddr] <= 1'b1;
    end
  end

  assign rd_data = rvld_r ? rdata_r : raddr_r;

endmodule

### rtl/rc4_key_ram.sv
// ----------------------------------------------------------------------------
// rc4_key_ram: key byte store
// One write and one registered read per cycle. Contents undefined until
// written.
// ----------------------------------------------------------------------------
module rc4_key_ram #(
  parameter int unsigned DEPTH = rc4_pkg::DEF_MAX_KEY_BYTES
) (
  input  logic              clk,
  input  rc4_pkg::key_req_t req,
  output logic [7:0]        rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    rdata_r <= mem[req.raddr[AW-1:0]];
  end

  assign rd_data = rdata_r;

endmodule

### rtl/rc4_core.sv
// ----------------------------------------------------------------------------
// rc4_core: RC4 sequencer
// Steps key scheduling, keystream discard and encryption through the
// permutation RAM with one shared 8-bit three-input adder.
// ----------------------------------------------------------------------------
module rc4_core #(
  parameter int unsigned MAX_KEY_BYTES = rc4_pkg::DEF_MAX_KEY_BYTES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [1:0]                       in_cmd,
  input  logic [7:0]                       in_key_index,
  input  logic [7:0]                       in_data,
  input  logic [rc4_pkg::KEY_LEN_W-1:0]    key_length,
  input  logic [rc4_pkg::DROP_W-1:0]       drop_count,
  input  logic                             res_ready,
  output logic                             idle,
  output logic                             res_valid,
  output rc4_pkg::res_t                    res
);

  localparam int unsigned KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [rc4_pkg::KEY_LEN_W-1:0] MAX_LEN = rc4_pkg::KEY_LEN_W'(MAX_KEY_BYTES);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_KSA_RD = 4'd1;
  localparam logic [3:0] ST_KSA_J  = 4'd2;
  localparam logic [3:0] ST_KSA_W1 = 4'd3;
  localparam logic [3:0] ST_KSA_W2 = 4'd4;
  localparam logic [3:0] ST_P_RD   = 4'd5;
  localparam logic [3:0] ST_P_J    = 4'd6;
  localparam logic [3:0] ST_P_W1   = 4'd7;
  localparam logic [3:0] ST_P_W2   = 4'd8;
  localparam logic [3:0] ST_P_KS   = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;

  logic [3:0]                   state_r, state_nxt;
  logic [7:0]                   i_r, i_nxt;
  logic [7:0]                   j_r, j_nxt;
  logic [7:0]                   a_r, a_nxt;
  logic [7:0]                   b_r, b_nxt;
  logic [KW-1:0]                kidx_r, kidx_nxt;
  logic [rc4_pkg::DROP_W-1:0]   drop_r, drop_nxt;
  logic                         dropping_r, dropping_nxt;
  logic [1:0]                   cmd_r, cmd_nxt;
  logic [7:0]                   data_r, data_nxt;
  rc4_pkg::res_t                res_r, res_nxt;

  rc4_pkg::perm_req_t           preq;
  rc4_pkg::key_req_t            kreq;
  logic [7:0]                   prd;
  logic [7:0]                   krd;

  logic [rc4_pkg::KEY_LEN_W-1:0] klen_eff;
  logic [rc4_pkg::DROP_W-1:0]    drop_eff;
  logic [7:0]                    op1, op2, op3, sum;

  rc4_perm_ram u_perm (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (preq),
    .rd_data (prd)
  );

  rc4_key_ram #(
    .DEPTH (MAX_KEY_BYTES)
  ) u_key (
    .clk     (clk),
    .req     (kreq),
    .rd_data (krd)
  );

  // key length clamped to 1..MAX, drop count to the discard limit
  always_comb begin
    if (key_length == '0) begin
      klen_eff = rc4_pkg::KEY_LEN_W'(1);
    end else if (key_length > MAX_LEN) begin
      klen_eff = MAX_LEN;
    end else begin
      klen_eff = key_length;
    end
    drop_eff = (drop_count > rc4_pkg::DROP_LIMIT) ? rc4_pkg::DROP_LIMIT : drop_count;
  end

  // the one shared adder
  always_comb begin
    op1 = '0;
    op2 = '0;
    op3 = '0;
    case (state_r)
      ST_KSA_J: begin
        op1 = j_r;
        op2 = prd;
        op3 = krd;
      end
      ST_KSA_W2, ST_P_RD: begin
        op1 = i_r;
        op2 = 8'd1;
      end
      ST_P_J: begin
        op1 = j_r;
        op2 = prd;
      end
      ST_P_W2: begin
        op1 = a_r;
        op2 = b_r;
      end
      default: begin
        op1 = '0;
      end
    endcase
    sum = op1 + op2 + op3;
  end

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    kidx_nxt     = kidx_r;
    drop_nxt     = drop_r;
    dropping_nxt = dropping_r;
    cmd_nxt      = cmd_r;
    data_nxt     = data_r;
    res_nxt      = res_r;
    preq         = '0;
    kreq         = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt  = in_cmd;
          data_nxt = in_data;
          res_nxt  = '0;
          case (in_cmd)
            rc4_pkg::CMD_LOAD: begin
              kreq.we    = (rc4_pkg::KEY_LEN_W'(in_key_index) < MAX_LEN);
              kreq.waddr = in_key_index;
              kreq.wdata = in_data;
              state_nxt  = ST_DONE;
            end
            rc4_pkg::CMD_SCHED: begin
              preq.clr  = 1'b1;
              i_nxt     = '0;
              j_nxt     = '0;
              kidx_nxt  = '0;
              state_nxt = ST_KSA_RD;
            end
            rc4_pkg::CMD_ENC: begin
              dropping_nxt = 1'b0;
              state_nxt    = ST_P_RD;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_KSA_RD: begin
        preq.raddr = i_r;
        kreq.raddr = 8'(kidx_r);
        state_nxt  = ST_KSA_J;
      end

      ST_KSA_J: begin
        a_nxt      = prd;
        j_nxt      = sum;
        preq.raddr = sum;
        state_nxt  = ST_KSA_W1;
      end

      ST_KSA_W1: begin
        preq.we    = 1'b1;
        preq.waddr = i_r;
        preq.wdata = prd;
        state_nxt  = ST_KSA_W2;
      end

      ST_KSA_W2: begin
        preq.we    = 1'b1;
        preq.waddr = j_r;
        preq.wdata = a_r;
        if (i_r == 8'hFF) begin
          i_nxt    = '0;
          j_nxt    = '0;
          drop_nxt = drop_eff;
          if (drop_eff == '0) begin
            state_nxt = ST_DONE;
          end else begin
            dropping_nxt = 1'b1;
            state_nxt    = ST_P_RD;
          end
        end else begin
          // next key byte wraps at the key length
          if (rc4_pkg::KEY_LEN_W'(kidx_r) + rc4_pkg::KEY_LEN_W'(1) == klen_eff) begin
            kidx_nxt = '0;
          end else begin
            kidx_nxt = kidx_r + KW'(1);
          end
          i_nxt      = sum;
          preq.raddr = sum;
          kreq.raddr = 8'(kidx_nxt);
          state_nxt  = ST_KSA_J;
        end
      end

      ST_P_RD: begin
        i_nxt      = sum;
        preq.raddr = sum;
        state_nxt  = ST_P_J;
      end

      ST_P_J: begin
        a_nxt      = prd;
        j_nxt      = sum;
        preq.raddr = sum;
        state_nxt  = ST_P_W1;
      end

      ST_P_W1: begin
        b_nxt      = prd;
        preq.we    = 1'b1;
        preq.waddr = i_r;
        preq.wdata = prd;
        state_nxt  = ST_P_W2;
      end

      ST_P_W2: begin
        preq.we    = 1'b1;
        preq.waddr = j_r;
        preq.wdata = a_r;
        preq.raddr = sum;
        state_nxt  = ST_P_KS;
      end

      ST_P_KS: begin
        if (dropping_r) begin
          drop_nxt = drop_r - rc4_pkg::DROP_W'(1);
          state_nxt = (drop_r == rc4_pkg::DROP_W'(1)) ? ST_DONE : ST_P_RD;
        end else begin
          res_nxt.result    = data_r ^ prd;
          res_nxt.keystream = prd;
          state_nxt         = ST_DONE;
        end
      end

      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      i_r        <= '0;
      j_r        <= '0;
      dropping_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      dropping_r <= dropping_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    kidx_r <= kidx_nxt;
    drop_r <= drop_nxt;
    cmd_r  <= cmd_nxt;
    data_r <= data_nxt;
    res_r  <= res_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

  // permutation is only written in the swap steps
  a_perm_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    preq.we |-> (state_r == ST_KSA_W1 || state_r == ST_KSA_W2 ||
                 state_r == ST_P_W1 || state_r == ST_P_W2))
    else $error("permutation write outside a swap step");

  a_kidx_in_key: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_KSA_J) |-> (rc4_pkg::KEY_LEN_W'(kidx_r) < klen_eff))
    else $error("key index beyond key length");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !res_ready) |=> (state_r == ST_DONE))
    else $error("result dropped while stalled");

  a_non_enc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && cmd_r != rc4_pkg::CMD_ENC) |->
      (res_r.result == 8'd0 && res_r.keystream == 8'd0))
    else $error("non-encrypt result not zero");

  a_drop_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_P_KS && dropping_r) |-> (drop_r != '0))
    else $error("discard counter underflow");

endmodule

### rtl/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher: RC4-drop[n] stream cipher engine
// Key store, key scheduling with keystream discard, and byte encryption
// behind stream-style input and output channels.
// ----------------------------------------------------------------------------
// Each input word is a command in in_tuser: load a key byte (key_index and
// byte in in_tdata), run the key schedule, or encrypt one byte. Every input
// word gives exactly one output word; loads and schedules return zeros. One
// word is in flight at a time and in_tready is low while it is worked on.
// Every keystream byte is a chain of dependent reads of the 256-entry
// permutation RAM (one read and one write port) followed by a two-write swap,
// so the cost is set by that RAM and the shared 8-bit adder. Each of the 256
// key scheduling steps runs the states KSA_J, KSA_W1 and KSA_W2; each
// encrypted or discarded byte runs P_RD, P_J, P_W1, P_W2 and P_KS. Loads
// and no-ops go straight from accept to DONE.
// The permutation returns to identity at reset and at each schedule by
// clearing per-entry valid bits at once; no clearing pass is needed.
// Key bytes read by the schedule must have been loaded first. Configuration
// writes (key_length, drop_count) are always accepted and must be made only
// while the engine is idle. A finished word waits in the output register
// while the engine takes the next input word.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
  parameter int unsigned MAX_KEY_BYTES = rc4_pkg::DEF_MAX_KEY_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] key_index, [15:8] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] command

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] result_byte, [15:8] keystream_byte

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,  // 0 key_length, 1 drop_count
  input  logic [12:0] cfg_data
);

  logic [rc4_pkg::KEY_LEN_W-1:0] key_length_r;
  logic [rc4_pkg::DROP_W-1:0]    drop_count_r;

  logic          out_tvalid_r;
  logic [15:0]   out_tdata_r;

  logic          core_idle;
  logic          res_valid;
  logic          res_ready;
  rc4_pkg::res_t res;
  logic          start;

  // config registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= rc4_pkg::KEY_LEN_W'(16);
      drop_count_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rc4_pkg::CFG_KEY_LENGTH: key_length_r <= cfg_data[rc4_pkg::KEY_LEN_W-1:0];
        rc4_pkg::CFG_DROP_COUNT: drop_count_r <= cfg_data;
        default: begin
          drop_count_r <= drop_count_r;
        end
      endcase
    end
  end

  assign in_tready = core_idle;
  assign start     = in_tvalid && core_idle;

  // output register frees the core while a word waits downstream
  assign res_ready = !out_tvalid_r || out_tready;

  rc4_core #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_cmd       (in_tuser),
    .in_key_index (in_tdata[7:0]),
    .in_data      (in_tdata[15:8]),
    .key_length   (key_length_r),
    .drop_count   (drop_count_r),
    .res_ready    (res_ready),
    .idle         (core_idle),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_tdata_r <= {res.keystream, res.result};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### tb/sv/rc4_stream_cipher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_stream_cipher_tb: self-checking bench for the RC4-drop[n] engine
// Drives load, schedule, encrypt and no-op words into the engine, predicts
// every output word with its own copy of the permutation, indices, key store
// and registers, and checks each output word field by field in order.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_tb;

  // unused command code: engine must answer with an all-zero word
  localparam logic [1:0] CMD_NOP = 2'd3;

  localparam int MISMATCH_SHOWN = 10;
  localparam int SETTLE_CYCLES  = 12;      // engine is idle once the last word is out
  localparam int STALL_LIMIT    = 100000;  // must outlast a 4096-byte discard with no handshake

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // [7:0] key_index, [15:8] data_byte
  logic [1:0]  in_tuser   = CMD_NOP; // [1:0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [7:0] result_byte, [15:8] keystream_byte
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = rc4_pkg::CFG_KEY_LENGTH;
  logic [12:0] cfg_data   = '0;

  rc4_stream_cipher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Cipher state as the bench sees it
  // --------------------------------------------------------------------------
  logic [7:0]  sbox [rc4_pkg::PERM_DEPTH];
  logic [7:0]  ks_i, ks_j;
  logic [7:0]  key_bytes [rc4_pkg::PERM_DEPTH];
  logic [8:0]  key_len_cfg;
  logic [12:0] drop_cfg;

  rc4_pkg::res_t due_words[$];   // output words owed by the engine, oldest first

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;  // forced output stall, counted down by the receiver

  int bad_words = 0;
  int words_in  = 0;
  int words_out = 0;
  int n_sched   = 0;
  int n_enc     = 0;

  initial begin
    for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++) begin
      sbox[n]      = n[7:0];
      key_bytes[n] = 8'h00;
    end
    ks_i        = 8'h00;
    ks_j        = 8'h00;
    key_len_cfg = 9'd16;
    drop_cfg    = 13'd0;
  end

  // one PRGA step: advance i/j, swap, return S[S[i]+S[j]]
  function automatic logic [7:0] keystream_next();
    logic [7:0] a, b, t;
    ks_i       = ks_i + 8'd1;
    a          = sbox[ks_i];
    ks_j       = ks_j + a;
    b          = sbox[ks_j];
    sbox[ks_i] = b;
    sbox[ks_j] = a;
    t          = a + b;
    return sbox[t];
  endfunction

  // KSA over the first key_length bytes, then discard drop_count bytes
  function automatic void key_schedule();
    int         klen, drops;
    logic [7:0] j, t;
    klen = key_len_cfg;
    if (klen == 0) klen = 1;
    if (klen > rc4_pkg::DEF_MAX_KEY_BYTES) klen = rc4_pkg::DEF_MAX_KEY_BYTES;
    for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++) sbox[n] = n[7:0];
    j = 8'h00;
    for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++) begin
      j       = j + sbox[n] + key_bytes[n % klen];
      t       = sbox[n];
      sbox[n] = sbox[j];
      sbox[j] = t;
    end
    ks_i  = 8'h00;
    ks_j  = 8'h00;
    drops = (drop_cfg > rc4_pkg::DROP_LIMIT) ? rc4_pkg::DROP_LIMIT : drop_cfg;
    repeat (drops) void'(keystream_next());
  endfunction

  function automatic rc4_pkg::res_t cipher_word(logic [1:0] cmd, logic [7:0] idx,
                                                logic [7:0] data);
    rc4_pkg::res_t w;
    logic [7:0]    ks;
    w = '0;
    case (cmd)
      rc4_pkg::CMD_LOAD:  key_bytes[idx] = data;
      rc4_pkg::CMD_SCHED: key_schedule();
      rc4_pkg::CMD_ENC: begin
        ks          = keystream_next();
        w.result    = data ^ ks;
        w.keystream = ks;
      end
      default: ;
    endcase
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers: inputs move on the falling edge, handshakes are judged
  // on the rising edge
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] idx,
                           input logic [7:0] data);
    int gap;
    @(negedge clk);
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {data, idx};
    do @(posedge clk); while (!in_tready);
    due_words.push_back(cipher_word(cmd, idx, data));
    words_in++;
    if (cmd == rc4_pkg::CMD_SCHED) n_sched++;
    if (cmd == rc4_pkg::CMD_ENC) n_enc++;
  endtask

  task automatic write_reg(input logic idx, input logic [12:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == rc4_pkg::CFG_KEY_LENGTH) key_len_cfg = val[8:0];
    else drop_cfg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop offering words, wait for every owed word, then let the engine go idle
  task automatic settle_engine();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_words.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls, plus a forced hold-off when asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Output checker
  // --------------------------------------------------------------------------
  task automatic report_bad(input string what, input rc4_pkg::res_t want,
                            input rc4_pkg::res_t got);
    bad_words++;
    if (bad_words <= MISMATCH_SHOWN)
      $display("%0t: %s: want result %02h keystream %02h, got result %02h keystream %02h",
               $realtime, what, want.result, want.keystream, got.result, got.keystream);
  endtask

  always @(posedge clk) begin : out_check
    rc4_pkg::res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = rc4_pkg::res_t'(out_tdata);
      words_out++;
      if (due_words.size() == 0) begin
        report_bad("output word with nothing owed", '0, got);
      end else begin
        want = due_words.pop_front();
        if (got.result !== want.result || got.keystream !== want.keystream)
          report_bad("output word mismatch", want, got);
      end
    end
  end

  // watchdog: ends the run after too long without any handshake
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no handshake for %0d cycles, %0d words owed", quiet, due_words.size());
    $display("FAIL rc4_stream_cipher");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // encrypt straight after reset runs on the identity permutation;
  // unused command code must return zeros and touch nothing
  task automatic test_identity_encrypt();
    send_word(rc4_pkg::CMD_ENC, 8'h00, 8'h00);
    send_word(rc4_pkg::CMD_ENC, 8'hFF, 8'hFF);
    send_word(CMD_NOP, 8'hFF, 8'hFF);
    send_word(rc4_pkg::CMD_ENC, 8'h5A, 8'hA5);
    send_word(CMD_NOP, 8'h00, 8'h00);
  endtask

  // every key byte is written before any schedule reads it
  task automatic test_key_fill();
    logic [7:0] kb;
    for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++) begin
      kb = (n == 0) ? 8'hFF : (n == rc4_pkg::PERM_DEPTH - 1) ? 8'h00 :
           8'($urandom_range(255));
      send_word(rc4_pkg::CMD_LOAD, n[7:0], kb);
    end
  endtask

  // reset register values (16 key bytes, no discard), schedule twice in a row
  task automatic test_default_schedule();
    send_word(rc4_pkg::CMD_SCHED, 8'h00, 8'h00);
    send_word(rc4_pkg::CMD_SCHED, 8'hFF, 8'hFF);
    send_word(rc4_pkg::CMD_ENC, 8'h00, 8'h00);
    send_word(rc4_pkg::CMD_ENC, 8'h3C, 8'hFF);
    send_word(rc4_pkg::CMD_ENC, 8'hC3, 8'h00);
    send_word(rc4_pkg::CMD_ENC, 8'h81, 8'h7E);
  endtask

  // key length zero acts as one, above 256 saturates
  task automatic test_key_length_edges();
    logic [8:0] klens [4];
    klens = '{9'd0, 9'd1, 9'd256, 9'd511};
    for (int n = 0; n < 4; n++) begin
      settle_engine();
      write_reg(rc4_pkg::CFG_KEY_LENGTH, {4'b0, klens[n]});
      send_word(rc4_pkg::CMD_SCHED, 8'($urandom_range(255)), 8'($urandom_range(255)));
      send_word(rc4_pkg::CMD_ENC, 8'($urandom_range(255)), 8'($urandom_range(255)));
      send_word(rc4_pkg::CMD_ENC, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  // full discard of 4096 bytes, and a count above that which saturates
  task automatic test_drop_edges();
    settle_engine();
    write_reg(rc4_pkg::CFG_KEY_LENGTH, 13'd13);
    write_reg(rc4_pkg::CFG_DROP_COUNT, 13'd4096);
    send_word(rc4_pkg::CMD_SCHED, 8'h00, 8'h00);
    send_word(rc4_pkg::CMD_ENC, 8'h11, 8'hEE);
    send_word(rc4_pkg::CMD_ENC, 8'h22, 8'hDD);
    settle_engine();
    write_reg(rc4_pkg::CFG_DROP_COUNT, 13'h1FFF);
    send_word(rc4_pkg::CMD_SCHED, 8'hFF, 8'hFF);
    send_word(rc4_pkg::CMD_ENC, 8'h44, 8'hBB);
    send_word(rc4_pkg::CMD_ENC, 8'h88, 8'h77);
  endtask

  // receiver holds off a long while; the engine must fill up and stall input
  task automatic test_output_hold_off();
    settle_engine();
    write_reg(rc4_pkg::CFG_DROP_COUNT, 13'd3);
    send_word(rc4_pkg::CMD_SCHED, 8'h00, 8'h00);
    hold_left = 400;
    repeat (24) send_word(rc4_pkg::CMD_ENC, 8'($urandom_range(255)), 8'($urandom_range(255)));
    settle_engine();
  endtask

  // random key sessions: optional new register values and rekey bytes, schedule,
  // a burst of encrypts with some no-ops, loads and mid-stream reschedules mixed in
  task automatic run_random_phase(input int send_pct, input int recv_pct, input int budget);
    int sent, burst, pick;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(3) == 0) begin
        settle_engine();
        write_reg(rc4_pkg::CFG_KEY_LENGTH, 13'($urandom_range(511)));
        write_reg(rc4_pkg::CFG_DROP_COUNT,
                  ($urandom_range(7) == 0) ? 13'($urandom_range(8191))
                                           : 13'($urandom_range(200)));
      end
      if ($urandom_range(5) == 0) begin
        burst = $urandom_range(1, 8);
        repeat (burst) begin
          send_word(rc4_pkg::CMD_LOAD, 8'($urandom_range(255)), 8'($urandom_range(255)));
          sent++;
        end
      end
      send_word(rc4_pkg::CMD_SCHED, 8'($urandom_range(255)), 8'($urandom_range(255)));
      sent++;
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        pick = $urandom_range(31);
        if (pick < 2) begin
          send_word(CMD_NOP, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end else begin
          if (pick < 4)
            send_word(rc4_pkg::CMD_LOAD, 8'($urandom_range(255)), 8'($urandom_range(255)));
          else if (pick == 4)
            send_word(rc4_pkg::CMD_SCHED, 8'($urandom_range(255)), 8'($urandom_range(255)));
          else
            send_word(rc4_pkg::CMD_ENC, 8'($urandom_range(255)), 8'($urandom_range(255)));
          sent++;
        end
      end
    end
  endtask

  task automatic test_random();
    run_random_phase(0, 0, 165);
    run_random_phase(72, 0, 165);
    run_random_phase(0, 72, 165);
    run_random_phase(12, 12, 165);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_identity_encrypt();
    test_key_fill();
    test_default_schedule();
    test_key_length_edges();
    test_drop_edges();
    test_output_hold_off();
    test_random();
    settle_engine();

    $display("covered %0d input words: %0d key schedules, %0d encrypts, rest loads/no-ops",
             words_in, n_sched, n_enc);
    $display("checked %0d output words over 4 idling mixes and a 400-cycle output stall",
             words_out);
    if (bad_words == 0 && due_words.size() == 0) begin
      $display("PASS rc4_stream_cipher");
    end else begin
      $display("%0d bad output words, %0d still owed", bad_words, due_words.size());
      $display("FAIL rc4_stream_cipher");
    end
    $finish;
  end

endmodule
